@@ sv/rsfh_pkg.sv @@
// ----------------------------------------------------------------------------
// rsfh_pkg
// Shared types and constants of the ray/segment nearest-hit core.
// ----------------------------------------------------------------------------
package rsfh_pkg;

  localparam int OPW    = 33;   // multiplier operand width, signed
  localparam int WORD_W = 64;   // products of two differences, parameters t
  localparam int ACC_W  = 128;  // accumulator and point numerators

  typedef struct packed {
    logic signed [OPW-1:0] sx;
    logic signed [OPW-1:0] sy;
    logic signed [OPW-1:0] dx;
    logic signed [OPW-1:0] dy;
    logic signed [OPW-1:0] ex;
    logic signed [OPW-1:0] ey;
    logic signed [OPW-1:0] wx;
    logic signed [OPW-1:0] wy;
    logic signed [OPW-1:0] bwx;
    logic signed [OPW-1:0] bwy;
    logic                  dzero;
    logic                  last;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_BASIC,
    B_CLASS,
    B_COLL,
    B_CSEL,
    B_CMP,
    B_CDEC,
    B_PT,
    B_DONE,
    B_DIV_X,
    B_DIV_Y,
    B_EMIT
  } bst_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_64
  } sh_t;

  function automatic logic signed [OPW-1:0] lo_half(input logic [WORD_W-1:0] v);
    lo_half = {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [OPW-1:0] hi_half(input logic [WORD_W-1:0] v);
    hi_half = {v[WORD_W-1], v[WORD_W-1:32]};
  endfunction

endpackage

@@ sv/rsfh_front.sv @@
// ----------------------------------------------------------------------------
// rsfh_front
// Ray registers, segment intake and difference vectors for the back end.
// ----------------------------------------------------------------------------
module rsfh_front #(
  parameter int COORD_BITS = 30
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [1:0]                              cfg_index,
  input  logic [COORD_BITS-1:0]                   cfg_data,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
  input  logic                                    s_tlast,
  output logic                                    push,
  output rsfh_pkg::item_t                         push_item,
  input  logic                                    full
);

  localparam int C = COORD_BITS;
  localparam int X = rsfh_pkg::OPW - COORD_BITS;

  localparam logic [1:0] REG_SRC_X = 2'd0;
  localparam logic [1:0] REG_SRC_Y = 2'd1;
  localparam logic [1:0] REG_DIR_X = 2'd2;
  localparam logic [1:0] REG_DIR_Y = 2'd3;

  logic [C-1:0] src_x, src_y, dir_x, dir_y;
  logic         fv;
  rsfh_pkg::item_t fent, item;

  function automatic logic signed [rsfh_pkg::OPW-1:0] ext(input logic [C-1:0] v);
    ext = {{X{v[C-1]}}, v};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      src_x <= '0;
      src_y <= '0;
      dir_x <= C'(1);
      dir_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_X: src_x <= cfg_data;
        REG_SRC_Y: src_y <= cfg_data;
        REG_DIR_X: dir_x <= cfg_data;
        REG_DIR_Y: dir_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.sx    = ext(src_x);
    item.sy    = ext(src_y);
    item.dx    = ext(dir_x) - ext(src_x);
    item.dy    = ext(dir_y) - ext(src_y);
    item.ex    = ext(s_tdata[3*C-1:2*C]) - ext(s_tdata[C-1:0]);
    item.ey    = ext(s_tdata[4*C-1:3*C]) - ext(s_tdata[2*C-1:C]);
    item.wx    = ext(s_tdata[C-1:0]) - ext(src_x);
    item.wy    = ext(s_tdata[2*C-1:C]) - ext(src_y);
    item.bwx   = ext(s_tdata[3*C-1:2*C]) - ext(src_x);
    item.bwy   = ext(s_tdata[4*C-1:3*C]) - ext(src_y);
    item.dzero = (dir_x == src_x) && (dir_y == src_y);
    item.last  = s_tlast;
  end

  assign push      = fv && !full;
  assign push_item = fent;
  assign s_tready  = !fv || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fent <= item;
    end
  end

endmodule

@@ sv/rsfh_fifo.sv @@
// ----------------------------------------------------------------------------
// rsfh_fifo
// Short item queue between front and back.
// ----------------------------------------------------------------------------
module rsfh_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rsfh_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output rsfh_pkg::item_t dout,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rsfh_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ sv/rsfh_div.sv @@
// ----------------------------------------------------------------------------
// rsfh_div
// Floor division of a point numerator by its denominator, one bit a cycle.
// ----------------------------------------------------------------------------
module rsfh_div #(
  parameter int COORD_BITS = 30
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [rsfh_pkg::ACC_W-1:0]      num,
  input  logic [rsfh_pkg::WORD_W-1:0]            den,
  output logic                                   done,
  output logic [COORD_BITS-1:0]                  quot
);

  localparam int Q  = COORD_BITS + 1;
  localparam int W  = rsfh_pkg::WORD_W;
  localparam int NW = $clog2(Q + 1);

  logic [rsfh_pkg::ACC_W-1:0] mag;
  logic [W:0]                 r, r2;
  logic [Q-1:0]               sh, q;
  logic [W-1:0]               d;
  logic                       neg, busy;
  logic [NW-1:0]              cnt;
  logic [Q:0]                 qe;

  assign mag = num[rsfh_pkg::ACC_W-1] ? -num : num;
  assign r2  = {r[W-1:0], sh[Q-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == NW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(Q);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= mag[W+Q:Q];
      sh  <= mag[Q-1:0];
      neg <= num[rsfh_pkg::ACC_W-1];
      d   <= den;
      q   <= '0;
    end else if (busy) begin
      sh <= {sh[Q-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        r <= r2 - {1'b0, d};
        q <= {q[Q-2:0], 1'b1};
      end else begin
        r <= r2;
        q <= {q[Q-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    qe = {1'b0, q} + {{Q{1'b0}}, (r != '0)};
    if (neg) begin
      qe = -qe;
    end else begin
      qe = {1'b0, q};
    end
  end

  assign quot = qe[COORD_BITS-1:0];

endmodule

@@ sv/rsfh_back.sv @@
// ----------------------------------------------------------------------------
// rsfh_back
// Sequencer on one shared multiply-accumulate unit: intersection, nearest
// hit tracking and result output.
// ----------------------------------------------------------------------------
module rsfh_back #(
  parameter int COORD_BITS = 30
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  empty,
  input  rsfh_pkg::item_t                       ent_in,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  output logic                                  m_tuser
);

  localparam int C     = COORD_BITS;
  localparam int OPW   = rsfh_pkg::OPW;
  localparam int W     = rsfh_pkg::WORD_W;
  localparam int A     = rsfh_pkg::ACC_W;

  rsfh_pkg::bst_t  state, state_next;
  logic [2:0]      step, step_next;
  rsfh_pkg::item_t ent;

  logic signed [A-1:0]     acc, acc_next, term0, term1, term;
  logic signed [2*OPW-1:0] prod;
  logic signed [OPW-1:0]   mac_a, mac_b;
  rsfh_pkg::sh_t           mac_sh;
  logic                    mac_en, mac_neg, mac_clr;

  logic signed [W-1:0] den_r, tn_r, un, tb, den_n, tn_n, un_n, lo, hi;
  logic [W-1:0]        ct, cd, bt, bd, cand_t, cand_d;
  logic                cand_load;
  logic [A-1:0]        xtmp, bxn, byn;
  logic                found;

  logic         div_start, div_sel_y, div_done;
  logic [C-1:0] div_quot, qx, qy;
  logic         emit;
  logic         ovalid, ohit;
  logic [C-1:0] ox, oy;

  rsfh_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_sel_y ? byn : bxn),
    .den   (bd),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign prod  = mac_a * mac_b;
  assign term0 = {{(A-2*OPW){prod[2*OPW-1]}}, prod};

  always_comb begin
    case (mac_sh)
      rsfh_pkg::SH_32: term1 = term0 <<< 32;
      rsfh_pkg::SH_64: term1 = term0 <<< 64;
      default:         term1 = term0;
    endcase
    term     = mac_neg ? -term1 : term1;
    acc_next = mac_clr ? term : acc + term;
  end

  assign un    = acc[W-1:0];
  assign tb    = acc[W-1:0];
  assign den_n = den_r[W-1] ? -den_r : den_r;
  assign tn_n  = den_r[W-1] ? -tn_r  : tn_r;
  assign un_n  = den_r[W-1] ? -un    : un;
  assign lo    = (tn_r < tb) ? tn_r : tb;
  assign hi    = (tn_r < tb) ? tb : tn_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsfh_pkg::B_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    pop        = 1'b0;
    mac_en     = 1'b0;
    mac_a      = '0;
    mac_b      = '0;
    mac_sh     = rsfh_pkg::SH_0;
    mac_neg    = 1'b0;
    mac_clr    = 1'b0;
    cand_load  = 1'b0;
    cand_t     = '0;
    cand_d     = '0;
    div_start  = 1'b0;
    div_sel_y  = 1'b0;
    emit       = 1'b0;
    case (state)
      rsfh_pkg::B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          step_next  = '0;
          state_next = rsfh_pkg::B_BASIC;
        end
      end
      rsfh_pkg::B_BASIC: begin
        mac_en    = 1'b1;
        step_next = step + 1'b1;
        case (step)
          3'd0: begin mac_a = ent.dx; mac_b = ent.ey; mac_clr = 1'b1; end
          3'd1: begin mac_a = ent.dy; mac_b = ent.ex; mac_neg = 1'b1; end
          3'd2: begin mac_a = ent.wx; mac_b = ent.ey; mac_clr = 1'b1; end
          3'd3: begin mac_a = ent.wy; mac_b = ent.ex; mac_neg = 1'b1; end
          3'd4: begin mac_a = ent.wx; mac_b = ent.dy; mac_clr = 1'b1; end
          default: begin mac_a = ent.wy; mac_b = ent.dx; mac_neg = 1'b1; end
        endcase
        if (step == 3'd5) begin
          state_next = rsfh_pkg::B_CLASS;
        end
      end
      rsfh_pkg::B_CLASS: begin
        state_next = rsfh_pkg::B_DONE;
        if (!ent.dzero) begin
          if (den_r != '0) begin
            if (!tn_n[W-1] && !un_n[W-1] && (un_n <= den_n)) begin
              cand_load  = 1'b1;
              cand_t     = tn_n;
              cand_d     = den_n;
              step_next  = '0;
              state_next = found ? rsfh_pkg::B_CMP : rsfh_pkg::B_PT;
            end
          end else if (un == '0) begin
            step_next  = '0;
            state_next = rsfh_pkg::B_COLL;
          end
        end
      end
      rsfh_pkg::B_COLL: begin
        mac_en    = 1'b1;
        step_next = step + 1'b1;
        case (step)
          3'd0: begin mac_a = ent.dx;  mac_b = ent.dx; mac_clr = 1'b1; end
          3'd1: begin mac_a = ent.dy;  mac_b = ent.dy; end
          3'd2: begin mac_a = ent.wx;  mac_b = ent.dx; mac_clr = 1'b1; end
          3'd3: begin mac_a = ent.wy;  mac_b = ent.dy; end
          3'd4: begin mac_a = ent.bwx; mac_b = ent.dx; mac_clr = 1'b1; end
          default: begin mac_a = ent.bwy; mac_b = ent.dy; end
        endcase
        if (step == 3'd5) begin
          state_next = rsfh_pkg::B_CSEL;
        end
      end
      rsfh_pkg::B_CSEL: begin
        state_next = rsfh_pkg::B_DONE;
        if (!hi[W-1]) begin
          cand_load  = 1'b1;
          cand_t     = lo[W-1] ? '0 : lo;
          cand_d     = lo[W-1] ? W'(1) : den_r;
          step_next  = '0;
          state_next = found ? rsfh_pkg::B_CMP : rsfh_pkg::B_PT;
        end
      end
      rsfh_pkg::B_CMP: begin
        mac_en    = 1'b1;
        step_next = step + 1'b1;
        case (step)
          3'd0: begin
            mac_a = rsfh_pkg::lo_half(ct); mac_b = rsfh_pkg::lo_half(bd); mac_clr = 1'b1;
          end
          3'd1: begin
            mac_a = rsfh_pkg::lo_half(ct); mac_b = rsfh_pkg::hi_half(bd);
            mac_sh = rsfh_pkg::SH_32;
          end
          3'd2: begin
            mac_a = rsfh_pkg::hi_half(ct); mac_b = rsfh_pkg::lo_half(bd);
            mac_sh = rsfh_pkg::SH_32;
          end
          3'd3: begin
            mac_a = rsfh_pkg::hi_half(ct); mac_b = rsfh_pkg::hi_half(bd);
            mac_sh = rsfh_pkg::SH_64;
          end
          3'd4: begin
            mac_a = rsfh_pkg::lo_half(bt); mac_b = rsfh_pkg::lo_half(cd); mac_neg = 1'b1;
          end
          3'd5: begin
            mac_a = rsfh_pkg::lo_half(bt); mac_b = rsfh_pkg::hi_half(cd);
            mac_sh = rsfh_pkg::SH_32; mac_neg = 1'b1;
          end
          3'd6: begin
            mac_a = rsfh_pkg::hi_half(bt); mac_b = rsfh_pkg::lo_half(cd);
            mac_sh = rsfh_pkg::SH_32; mac_neg = 1'b1;
          end
          default: begin
            mac_a = rsfh_pkg::hi_half(bt); mac_b = rsfh_pkg::hi_half(cd);
            mac_sh = rsfh_pkg::SH_64; mac_neg = 1'b1;
          end
        endcase
        if (step == 3'd7) begin
          state_next = rsfh_pkg::B_CDEC;
        end
      end
      rsfh_pkg::B_CDEC: begin
        step_next  = '0;
        state_next = acc[A-1] ? rsfh_pkg::B_PT : rsfh_pkg::B_DONE;
      end
      rsfh_pkg::B_PT: begin
        mac_en    = 1'b1;
        step_next = step + 1'b1;
        case (step)
          3'd0: begin mac_a = ent.sx; mac_b = rsfh_pkg::lo_half(cd); mac_clr = 1'b1; end
          3'd1: begin
            mac_a = ent.sx; mac_b = rsfh_pkg::hi_half(cd); mac_sh = rsfh_pkg::SH_32;
          end
          3'd2: begin mac_a = rsfh_pkg::lo_half(ct); mac_b = ent.dx; end
          3'd3: begin
            mac_a = rsfh_pkg::hi_half(ct); mac_b = ent.dx; mac_sh = rsfh_pkg::SH_32;
          end
          3'd4: begin mac_a = ent.sy; mac_b = rsfh_pkg::lo_half(cd); mac_clr = 1'b1; end
          3'd5: begin
            mac_a = ent.sy; mac_b = rsfh_pkg::hi_half(cd); mac_sh = rsfh_pkg::SH_32;
          end
          3'd6: begin mac_a = rsfh_pkg::lo_half(ct); mac_b = ent.dy; end
          default: begin
            mac_a = rsfh_pkg::hi_half(ct); mac_b = ent.dy; mac_sh = rsfh_pkg::SH_32;
          end
        endcase
        if (step == 3'd7) begin
          state_next = rsfh_pkg::B_DONE;
        end
      end
      rsfh_pkg::B_DONE: begin
        if (!ent.last) begin
          state_next = rsfh_pkg::B_IDLE;
        end else if (found) begin
          div_start  = 1'b1;
          state_next = rsfh_pkg::B_DIV_X;
        end else begin
          state_next = rsfh_pkg::B_EMIT;
        end
      end
      rsfh_pkg::B_DIV_X: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_sel_y  = 1'b1;
          state_next = rsfh_pkg::B_DIV_Y;
        end
      end
      rsfh_pkg::B_DIV_Y: begin
        div_sel_y = 1'b1;
        if (div_done) begin
          state_next = rsfh_pkg::B_EMIT;
        end
      end
      rsfh_pkg::B_EMIT: begin
        if (!ovalid || m_tready) begin
          emit       = 1'b1;
          state_next = rsfh_pkg::B_IDLE;
        end
      end
      default: state_next = rsfh_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= ent_in;
    end
    if (mac_en) begin
      acc <= acc_next;
    end
    if ((state == rsfh_pkg::B_BASIC || state == rsfh_pkg::B_COLL) && step == 3'd1) begin
      den_r <= acc_next[W-1:0];
    end
    if ((state == rsfh_pkg::B_BASIC || state == rsfh_pkg::B_COLL) && step == 3'd3) begin
      tn_r <= acc_next[W-1:0];
    end
    if (cand_load) begin
      ct <= cand_t;
      cd <= cand_d;
    end
    if (state == rsfh_pkg::B_PT && step == 3'd3) begin
      xtmp <= acc_next;
    end
    if (state == rsfh_pkg::B_PT && step == 3'd7) begin
      bt  <= ct;
      bd  <= cd;
      bxn <= xtmp;
      byn <= acc_next;
    end
    if (state == rsfh_pkg::B_DIV_X && div_done) begin
      qx <= div_quot;
    end
    if (state == rsfh_pkg::B_DIV_Y && div_done) begin
      qy <= div_quot;
    end
    if (emit) begin
      ohit <= found;
      ox   <= found ? qx : '0;
      oy   <= found ? qy : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (state == rsfh_pkg::B_PT && step == 3'd7) begin
        found <= 1'b1;
      end else if (emit) begin
        found <= 1'b0;
      end
      if (emit) begin
        ovalid <= 1'b1;
      end else if (m_tready) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign m_tvalid = ovalid;
  assign m_tuser  = ohit;

  always_comb begin
    m_tdata          = '0;
    m_tdata[C-1:0]   = ox;
    m_tdata[2*C-1:C] = oy;
  end

endmodule

@@ sv/ray_segment_first_hit_core.sv @@
// ----------------------------------------------------------------------------
// ray_segment_first_hit_core
// Nearest meeting point of a ray with a stream of segments, exact rational
// arithmetic; one result on each segment marked last.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid / tready    tdata: seg_ax, seg_ay, seg_bx, seg_by; tlast: last
//   m_*      out  tvalid / tready    tdata: hit_x, hit_y; tuser: hit
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// In the back sequencer a crossing miss takes the shortest path, a collinear
// miss a longer one and a collinear overlap that beats a kept hit the longest;
// all products go through one shared 33x33 MAC. A last segment adds an output
// step, plus bit-serial division of both coordinates when a hit is kept. rst
// is synchronous; no clearing pass. The front and a two-entry queue keep
// taking segments while the back works or the output stalls.
// ----------------------------------------------------------------------------
module ray_segment_first_hit_core #(
  parameter int COORD_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // seg_ax, seg_ay, seg_bx, seg_by
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // hit_x, hit_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  // hit
  output logic                                 m_tuser
);

  logic            push, full, pop, empty;
  rsfh_pkg::item_t push_item, head;

  rsfh_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  rsfh_fifo #(.DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_item),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  rsfh_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .ent_in   (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ verif/tb_ray_segment_first_hit_core.sv @@
// ----------------------------------------------------------------------------
// tb_ray_segment_first_hit_core
// Streams sets of segments against a configured ray and checks each hit
// result against a cycle-free exact predictor, across several ray settings
// and idling patterns on both sides of the core.
// ----------------------------------------------------------------------------
module tb_ray_segment_first_hit_core;

  localparam int  CW   = 30;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam int  WDOG = 20000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] crd_t;

  typedef enum logic [1:0] {
    REG_SRC_X,
    REG_SRC_Y,
    REG_DIR_X,
    REG_DIR_Y
  } reg_idx_t;

  typedef struct {
    bit   hit;
    crd_t x;
    crd_t y;
  } hit_t;

  typedef struct {
    longint ax, ay, bx, by;
    bit     lst;
    bit     known;
    bit     hit;
    longint x, y;
  } seg_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [4*CW-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic m_tuser;

  ray_segment_first_hit_core #(.COORD_BITS(CW)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  // ray registers as the core holds them, and the kept hit
  crd_t   ray_sx = 0, ray_sy = 0, ray_px = 1, ray_py = 0;
  bit     kept;
  longint kept_t, kept_den;
  wide_t  kept_xn, kept_yn;

  hit_t   hit_q[$];
  int     mismatches = 0;
  int     snd_idle = 0, rcv_stall = 0;
  int     quiet = 0;
  seg_row_t rows[$];

  task automatic keep_nearest(input longint tn, input longint td, input longint sx,
                              input longint sy, input longint dx, input longint dy);
    if (kept && !(wide_t'(tn) * wide_t'(kept_den) < wide_t'(kept_t) * wide_t'(td)))
      return;
    kept     = 1;
    kept_t   = tn;
    kept_den = td;
    kept_xn  = wide_t'(sx) * wide_t'(td) + wide_t'(tn) * wide_t'(dx);
    kept_yn  = wide_t'(sy) * wide_t'(td) + wide_t'(tn) * wide_t'(dy);
  endtask

  function automatic crd_t floor_coord(input wide_t n, input longint d);
    wide_t q;
    q = n / wide_t'(d);
    if (n < 0 && q * wide_t'(d) != n) q = q - 1;
    return q[CW-1:0];
  endfunction

  task automatic clear_hit();
    kept = 0; kept_t = 0; kept_den = 1; kept_xn = 0; kept_yn = 0;
  endtask

  task automatic nearest_hit_step(input crd_t ax, input crd_t ay, input crd_t bx,
                                  input crd_t by, input bit lst, output hit_t r);
    longint sx, sy, dx, dy, ex, ey, wx, wy, den, tn, un, dd, ta, tb, lo, hi;
    sx = ray_sx; sy = ray_sy;
    dx = longint'(ray_px) - sx; dy = longint'(ray_py) - sy;
    ex = longint'(bx) - ax; ey = longint'(by) - ay;
    wx = longint'(ax) - sx; wy = longint'(ay) - sy;
    if (dx != 0 || dy != 0) begin
      den = dx * ey - dy * ex;
      if (den != 0) begin
        tn = wx * ey - wy * ex;
        un = wx * dy - wy * dx;
        if (den < 0) begin
          den = -den; tn = -tn; un = -un;
        end
        if (tn >= 0 && un >= 0 && un <= den) keep_nearest(tn, den, sx, sy, dx, dy);
      end else if (wx * dy - wy * dx == 0) begin
        dd = dx * dx + dy * dy;
        ta = wx * dx + wy * dy;
        tb = (longint'(bx) - sx) * dx + (longint'(by) - sy) * dy;
        lo = ta < tb ? ta : tb;
        hi = ta < tb ? tb : ta;
        if (hi >= 0) begin
          if (lo >= 0) keep_nearest(lo, dd, sx, sy, dx, dy);
          else keep_nearest(0, 1, sx, sy, dx, dy);
        end
      end
    end
    r.hit = kept;
    r.x = kept ? floor_coord(kept_xn, kept_den) : '0;
    r.y = kept ? floor_coord(kept_yn, kept_den) : '0;
    if (lst) clear_hit();
  endtask

  task automatic send_seg(input crd_t ax, input crd_t ay, input crd_t bx, input crd_t by,
                          input bit lst, input bit known, input hit_t known_r);
    hit_t r;
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {by, bx, ay, ax};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    nearest_hit_step(ax, ay, bx, by, lst, r);
    if (lst) hit_q.push_back(known ? known_r : r);
  endtask

  task automatic write_reg(input reg_idx_t idx, input crd_t val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SRC_X: ray_sx = val;
      REG_SRC_Y: ray_sy = val;
      REG_DIR_X: ray_px = val;
      default:   ray_py = val;
    endcase
  endtask

  task automatic set_ray(input longint sx, input longint sy, input longint px,
                         input longint py);
    write_reg(REG_SRC_X, crd_t'(sx));
    write_reg(REG_SRC_Y, crd_t'(sy));
    write_reg(REG_DIR_X, crd_t'(px));
    write_reg(REG_DIR_Y, crd_t'(py));
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (hit_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic crd_t clampc(input longint v);
    return crd_t'(v < CMIN ? CMIN : (v > CMAX ? CMAX : v));
  endfunction

  function automatic longint jitter(input longint span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  function automatic crd_t any_coord();
    return crd_t'($urandom());
  endfunction

  task automatic random_seg(output crd_t ax, output crd_t ay, output crd_t bx,
                            output crd_t by);
    longint sx, sy, dx, dy, cx, cy, sp;
    int m, k1, k2;
    sx = ray_sx; sy = ray_sy;
    dx = longint'(ray_px) - sx; dy = longint'(ray_py) - sy;
    m  = $urandom_range(99);
    k1 = $urandom_range(16);
    k2 = int'($urandom_range(6)) - 3;
    cx = sx + dx * k1 / 8;
    cy = sy + dy * k1 / 8;
    sp = $urandom_range(3) == 0 ? (64'sd1 <<< 28) : 64;
    if (m < 35) begin
      ax = clampc(cx + jitter(sp)); ay = clampc(cy + jitter(sp));
      bx = clampc(cx + jitter(sp)); by = clampc(cy + jitter(sp));
    end else if (m < 50) begin
      ax = clampc(sx + dx * (k1 % 5 - 2)); ay = clampc(sy + dy * (k1 % 5 - 2));
      bx = clampc(sx + dx * k2);           by = clampc(sy + dy * k2);
    end else if (m < 60) begin
      ax = clampc(cx); ay = clampc(cy + ($urandom_range(2) == 0 ? 1 : 0));
      bx = ax; by = ay;
    end else if (m < 80) begin
      ax = clampc(sx + jitter(64)); ay = clampc(sy + jitter(64));
      bx = clampc(sx + jitter(64)); by = clampc(sy + jitter(64));
    end else begin
      ax = any_coord(); ay = any_coord(); bx = any_coord(); by = any_coord();
    end
  endtask

  always @(posedge clk) begin
    m_tready <= rcv_stall == 0 || $urandom_range(99) >= rcv_stall;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: hit=%0b x=%0d y=%0d",
                                       m_tuser, $signed(m_tdata[CW-1:0]),
                                       $signed(m_tdata[2*CW-1:CW]));
      end else if (hit_q[0].hit !== m_tuser || hit_q[0].x !== m_tdata[CW-1:0]
                   || hit_q[0].y !== m_tdata[2*CW-1:CW]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("hit mismatch: expected %0b (%0d,%0d) got %0b (%0d,%0d)",
                   hit_q[0].hit, hit_q[0].x, hit_q[0].y, m_tuser,
                   $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]));
        void'(hit_q.pop_front());
      end else begin
        void'(hit_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    hit_t kr;
    crd_t ax, ay, bx, by;
    int   n, left;
    clear_hit();
    // ray from the origin along +x after reset
    rows = '{
      '{5, -3, 5, 3, 1, 1, 1, 5, 0},
      '{-5, -3, -5, 3, 1, 1, 0, 0, 0},
      '{0, 1, 10, 1, 1, 1, 0, 0, 0},
      '{3, 0, 8, 0, 1, 1, 1, 3, 0},
      '{-4, 0, 6, 0, 1, 1, 1, 0, 0},
      '{7, 0, 7, 0, 1, 1, 1, 7, 0},
      '{7, 1, 7, 1, 1, 1, 0, 0, 0},
      '{9, -1, 9, 1, 0, 0, 0, 0, 0},
      '{4, -1, 4, 1, 0, 0, 0, 0, 0},
      '{4, -2, 4, 2, 1, 1, 1, 4, 0},
      '{1, -1, 2, 1, 1, 1, 1, 1, 0},
      '{CMAX, CMIN, CMAX, CMAX, 1, 1, 1, CMAX, 0},
      '{CMIN, CMIN, CMAX, CMAX, 1, 0, 0, 0, 0},
      '{6, 0, 6, 5, 1, 1, 1, 6, 0},
      '{6, 1, 6, 5, 1, 1, 0, 0, 0},
      '{0, 0, 0, 0, 1, 1, 1, 0, 0},
      '{CMIN, CMIN, CMIN, CMIN, 1, 1, 0, 0, 0},
      '{CMAX, CMAX, CMIN, CMIN, 0, 0, 0, 0, 0},
      '{-3, 5, 3, -4, 1, 0, 0, 0, 0},
      '{CMIN, 0, CMAX, 0, 1, 1, 1, 0, 0}
    };
    repeat (4) @(posedge clk);
    rst <= 0;
    foreach (rows[i]) begin
      kr.hit = rows[i].hit; kr.x = crd_t'(rows[i].x); kr.y = crd_t'(rows[i].y);
      send_seg(crd_t'(rows[i].ax), crd_t'(rows[i].ay), crd_t'(rows[i].bx),
               crd_t'(rows[i].by), rows[i].lst, rows[i].known, kr);
    end
    s_tvalid <= 0;
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 70; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 70; end
        default: begin snd_idle = 22; rcv_stall = 22; end
      endcase
      case (p)
        1: set_ray(CMIN, CMIN, CMAX, CMAX);
        2: set_ray(CMAX, CMAX, CMIN, CMAX);
        3: begin
          ax = any_coord(); ay = any_coord();
          set_ray(ax, ay, ax, ay);
        end
        4: set_ray(any_coord(), any_coord(), any_coord(), any_coord());
        6: set_ray(CMAX, CMIN, CMIN, CMAX);
        default: begin
          n = int'($urandom_range(100)) - 50;
          left = int'($urandom_range(100)) - 50;
          set_ray(n, left, n + jitter(20), left + jitter(20));
        end
      endcase
      left = 200;
      while (left > 0) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          random_seg(ax, ay, bx, by);
          send_seg(ax, ay, bx, by, i == n - 1, 0, kr);
          left--;
        end
      end
      s_tvalid <= 0;
      drain();
    end

    if (mismatches == 0 && hit_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
